[hdl/lcg48_pkg.sv]
// Shared types, constants and helpers for the 48-bit LCG generator.
package lcg48_pkg;

    localparam int SEED_W      = 48;
    localparam int DIV_W       = 31;
    localparam int MUL_CHUNK_W = 12;
    localparam int MUL_CHUNKS  = 3;
    localparam int MUL_CNT_W   = $clog2(MUL_CHUNKS);

    localparam logic [SEED_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [SEED_W-1:0] LCG_INC  = 48'h0000_0000_000B;

    localparam logic [2:0] FUNC_BITS     = 3'd0;
    localparam logic [2:0] FUNC_BOUNDED  = 3'd1;
    localparam logic [2:0] FUNC_LONG     = 3'd2;
    localparam logic [2:0] FUNC_DOUBLE   = 3'd3;
    localparam logic [2:0] FUNC_SET_SEED = 3'd4;
    localparam logic [2:0] FUNC_GET_SEED = 3'd5;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         bit_count;
        logic signed [31:0] bound;
        logic [47:0]        new_seed;
    } req_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               error;
    } rsp_t;

    // One slice of the multiplier constant per multiply step.
    function automatic logic [MUL_CHUNK_W-1:0] mult_chunk(input logic [MUL_CNT_W-1:0] idx);
        logic [MUL_CHUNK_W-1:0] c;
        case (idx)
            2'd0:    c = LCG_MULT[11:0];
            2'd1:    c = LCG_MULT[23:12];
            2'd2:    c = LCG_MULT[35:24];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[hdl/lcg48_mul.sv]
// Multi-cycle LCG advance: seed * multiplier + increment, mod 2^48, one slice a cycle.
module lcg48_mul
    import lcg48_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SEED_W-1:0] seed_in,
    output logic              done,
    output logic [SEED_W-1:0] seed_out
);

    localparam int PROD_W = SEED_W + MUL_CHUNK_W;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SEED_W-1:0]    acc_reg, acc_next;
    logic [SEED_W-1:0]    src_reg, src_next;
    logic [PROD_W-1:0]    prod;

    always_comb
    begin
        prod      = PROD_W'(src_reg) * PROD_W'(mult_chunk(cnt_reg));
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        src_next  = src_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = LCG_INC;
            src_next  = seed_in;
        end
        else if (busy_reg)
        begin
            // accumulate this slice, shift the seed up for the next one
            acc_next = acc_reg + prod[SEED_W-1:0];
            src_next = src_reg << MUL_CHUNK_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_CHUNKS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        src_reg <= src_next;
    end

    assign done     = done_reg;
    assign seed_out = acc_reg;

endmodule

[hdl/lcg48_rem.sv]
// Restoring remainder unit, one quotient bit a cycle.
module lcg48_rem
    import lcg48_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the difference when the trial covers the divisor
            rem_next = (trial >= {1'b0, dsr_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hdl/lcg48_uniform_generator.sv]
// Top level of the 48-bit LCG uniform generator: request sequencer and output register.
//
// Requests arrive on req/req_valid/req_ready, one result leaves on rsp/rsp_valid/rsp_ready
// for every request. req.func picks top bits, bounded integer, long, 53-bit fraction,
// raw seed load or seed read. One request is in work at a time; req_ready is high only
// while the sequencer is idle, which starts in the same cycle a result enters the output
// register. Each draw runs the shared multiply unit for three slice steps. Top bits and a
// power-of-two bound take one draw, long and fraction two; seed load, seed read, unused
// codes and a bound at or below zero take none. A bounded request with a bound that is
// not a power of two runs the remainder unit after every draw and retries while the
// draw falls into the rejected top range.
// seed_we/seed_wdata loads the state with the value xored with the multiplier; write it
// only while no request is in work.
// Reset puts the scrambled zero seed in the state and empties the output register.
// A finished result waits in the output register while the receiver stalls; the next
// request is taken meanwhile and its result is held, with req_ready low, until the
// register frees.
module lcg48_uniform_generator
    import lcg48_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              seed_we,
    input  logic [SEED_W-1:0] seed_wdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DRAW   = 4'b0010,
        S_REM    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [SEED_W-1:0] lcg_state_reg, lcg_state_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    rsp_t              res_reg, res_next;
    logic [2:0]        func_reg, func_next;
    logic [5:0]        nb_reg, nb_next;
    logic [31:0]       bound_reg, bound_next;
    logic              phase_reg, phase_next;
    logic [31:0]       hi_reg, hi_next;
    logic [DIV_W-1:0]  b_reg, b_next;

    logic              mul_start, mul_done;
    logic [SEED_W-1:0] mul_seed_in, mul_seed_out;
    logic              rem_start, rem_done;
    logic [DIV_W-1:0]  rem_out;

    logic [5:0]        nb_sel;
    logic [5:0]        shamt;
    logic [31:0]       word;
    logic [63:0]       pow_prod;
    logic [31:0]       chk;
    logic              pow2;

    lcg48_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .seed_in  (mul_seed_in),
        .done     (mul_done),
        .seed_out (mul_seed_out)
    );

    lcg48_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (word[DIV_W-1:0]),
        .divisor   (bound_reg[DIV_W-1:0]),
        .done      (rem_done),
        .remainder (rem_out)
    );

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (func_reg)
            FUNC_BITS:    nb_sel = nb_reg;
            FUNC_LONG:    nb_sel = 6'd32;
            FUNC_DOUBLE:  nb_sel = phase_reg ? 6'd27 : 6'd26;
            default:      nb_sel = 6'd31;
        endcase
        shamt    = 6'(SEED_W) - nb_sel;
        word     = 32'(mul_seed_out >> shamt);
        pow_prod = {32'b0, bound_reg} * {32'b0, word};
        pow2     = ((bound_reg & (bound_reg - 32'd1)) == 32'd0);
        chk      = {1'b0, b_reg} - {1'b0, rem_out} + bound_reg - 32'd1;
        // chain a second draw straight from the fresh seed
        mul_seed_in = mul_done ? mul_seed_out : lcg_state_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        lcg_state_next = lcg_state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        func_next      = func_reg;
        nb_next        = nb_reg;
        bound_next     = bound_reg;
        phase_next     = phase_reg;
        hi_next        = hi_reg;
        b_next         = b_reg;
        mul_start      = 1'b0;
        rem_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    bound_next = req.bound;
                    phase_next = 1'b0;
                    if (req.bit_count == 6'd0)
                        nb_next = 6'd1;
                    else if (req.bit_count > 6'd32)
                        nb_next = 6'd32;
                    else
                        nb_next = req.bit_count;
                    res_next = '0;
                    unique case (req.func)
                        FUNC_BITS, FUNC_LONG, FUNC_DOUBLE:
                        begin
                            mul_start  = 1'b1;
                            state_next = S_DRAW;
                        end
                        FUNC_BOUNDED:
                        begin
                            if (req.bound[31] || req.bound == 32'sd0)
                            begin
                                res_next.error = 1'b1;
                                state_next     = S_FINISH;
                            end
                            else
                            begin
                                mul_start  = 1'b1;
                                state_next = S_DRAW;
                            end
                        end
                        FUNC_SET_SEED:
                        begin
                            lcg_state_next = req.new_seed;
                            state_next     = S_FINISH;
                        end
                        FUNC_GET_SEED:
                        begin
                            res_next.value = 64'(lcg_state_reg);
                            state_next     = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_DRAW:
            begin
                if (mul_done)
                begin
                    lcg_state_next = mul_seed_out;
                    res_next       = '0;
                    unique case (func_reg)
                        FUNC_BITS:
                        begin
                            res_next.value = {{32{word[31]}}, word};
                            state_next     = S_FINISH;
                        end
                        FUNC_BOUNDED:
                        begin
                            if (pow2)
                            begin
                                res_next.value = {31'b0, pow_prod[63:31]};
                                state_next     = S_FINISH;
                            end
                            else
                            begin
                                b_next     = word[DIV_W-1:0];
                                rem_start  = 1'b1;
                                state_next = S_REM;
                            end
                        end
                        FUNC_LONG, FUNC_DOUBLE:
                        begin
                            if (!phase_reg)
                            begin
                                // hold the first word, draw the second
                                hi_next    = word;
                                phase_next = 1'b1;
                                mul_start  = 1'b1;
                            end
                            else
                            begin
                                if (func_reg == FUNC_LONG)
                                    res_next.value = {hi_reg, 32'b0} + {{32{word[31]}}, word};
                                else
                                    res_next.value = {11'b0, hi_reg[25:0], word[26:0]};
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_REM:
            begin
                if (rem_done)
                begin
                    if (chk[31])
                    begin
                        // reject the draw and advance again
                        mul_start  = 1'b1;
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        res_next       = '0;
                        res_next.value = 64'(rem_out);
                        state_next     = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (seed_we)
            lcg_state_next = seed_wdata ^ LCG_MULT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lcg_state_reg <= LCG_MULT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcg_state_reg <= lcg_state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        res_reg   <= res_next;
        func_reg  <= func_next;
        nb_reg    <= nb_next;
        bound_reg <= bound_next;
        phase_reg <= phase_next;
        hi_reg    <= hi_next;
        b_reg     <= b_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_mul_done_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_DRAW)
        else $error("multiply result outside draw state");

    a_rem_done_in_rem: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == S_REM)
        else $error("remainder result outside remainder state");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg != S_IDLE)
        else $error("sequencer idle after request transfer");

    a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && (!rsp_valid || rsp_ready) |=> rsp_valid && state_reg == S_IDLE)
        else $error("finished result not moved to output register");
`endif

endmodule

[verif/lcg48_uniform_generator_tb.sv]
// Self-checking testbench for the 48-bit LCG uniform generator.
`timescale 1ns / 1ps

module lcg48_uniform_generator_tb
    import lcg48_pkg::*;
();

    localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_ITEMS   = 100;
    localparam int         HOLD_CYCLES   = 400;

    // Mirror of the generator state; computes the result owed for each request.
    class lcg_draw_checker;
        logic [SEED_W-1:0] lcg_state;
        rsp_t              rsp_due[$];
        int                fails;

        function new();
            lcg_state = LCG_MULT;
            fails     = 0;
        endfunction

        function void load_seed(logic [SEED_W-1:0] s);
            lcg_state = s ^ LCG_MULT;
        endfunction

        // Advance the seed and return its top nb bits.
        function logic [31:0] step_seed(int nb);
            logic [SEED_W-1:0] top;
            lcg_state = lcg_state * LCG_MULT + LCG_INC;
            top = lcg_state >> (SEED_W - nb);
            return top[31:0];
        endfunction

        function int owed();
            return rsp_due.size();
        endfunction

        function void take_request(req_t r);
            logic [31:0] n, b, v, t, hi, lo;
            logic [63:0] prod, val;
            int          nb;
            rsp_t        e;
            val     = '0;
            e.error = 1'b0;
            case (r.func)
                FUNC_BITS:
                begin
                    nb = r.bit_count;
                    if (nb < 1) nb = 1;
                    if (nb > 32) nb = 32;
                    b   = step_seed(nb);
                    val = {{32{b[31]}}, b};
                end
                FUNC_BOUNDED:
                begin
                    n = r.bound;
                    if (n == 32'd0 || n[31])
                    begin
                        e.error = 1'b1;
                    end
                    else if ((n & (n - 32'd1)) == 32'd0)
                    begin
                        b    = step_seed(31);
                        prod = {32'd0, n} * {32'd0, b};
                        val  = prod >> 31;
                    end
                    else
                    begin
                        b = step_seed(31);
                        v = b % n;
                        t = b - v + n - 32'd1;
                        // redraw while the draw lands in the biased top range
                        while (t[31])
                        begin
                            b = step_seed(31);
                            v = b % n;
                            t = b - v + n - 32'd1;
                        end
                        val = {32'd0, v};
                    end
                end
                FUNC_LONG:
                begin
                    hi  = step_seed(32);
                    lo  = step_seed(32);
                    val = {hi, 32'd0} + {{32{lo[31]}}, lo};
                end
                FUNC_DOUBLE:
                begin
                    hi  = step_seed(26);
                    lo  = step_seed(27);
                    val = ({32'd0, hi} << 27) + {32'd0, lo};
                end
                FUNC_SET_SEED: lcg_state = r.new_seed;
                FUNC_GET_SEED: val = {16'd0, lcg_state};
                default: ;
            endcase
            e.value = val;
            rsp_due.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (rsp_due.size() == 0)
            begin
                $error("result with no request outstanding: value %h error %b",
                       got.value, got.error);
                fails++;
                return;
            end
            e = rsp_due.pop_front();
            if (got.value !== e.value)
            begin
                $error("value: expected %h, actual %h", e.value, got.value);
                fails++;
            end
            if (got.error !== e.error)
            begin
                $error("error: expected %b, actual %b", e.error, got.error);
                fails++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_ready;
    req_t              req        = '0;
    logic              rsp_valid;
    logic              rsp_ready  = 1'b0;
    rsp_t              rsp;
    logic              seed_we    = 1'b0;
    logic [SEED_W-1:0] seed_wdata = '0;

    lcg_draw_checker sb;
    bit              calm;
    bit              hold_now;
    int              cycles;

    lcg48_uniform_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Note every transfer on both channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready) sb.check_result(rsp);
            if (req_valid && req_ready) sb.take_request(req);
        end
    end

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        int  stall_left;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_now && !held)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (calm)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 36);
        end
    end

    function automatic req_t make_req(logic [2:0] f, logic [5:0] bc,
                                      logic [31:0] bnd, logic [SEED_W-1:0] sd);
        req_t r;
        r.func      = f;
        r.bit_count = bc;
        r.bound     = bnd;
        r.new_seed  = sd;
        return r;
    endfunction

    function automatic logic [SEED_W-1:0] random_seed();
        logic [SEED_W-1:0] s;
        case ($urandom_range(9))
            0:       s = '0;
            1:       s = '1;
            default: s = {16'($urandom), $urandom};
        endcase
        return s;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int          pick;
        logic [31:0] bnd;
        pick = $urandom_range(99);
        case ($urandom_range(7))
            0:       bnd = $urandom_range(100, 1);
            1:       bnd = 32'd1 << $urandom_range(30);
            2:       bnd = $urandom;
            3:       bnd = 32'h4000_0000 + $urandom_range(32'h3FFF_FFFF, 1);
            4:       bnd = 32'd0;
            5:       bnd = $urandom | 32'h8000_0000;
            default: bnd = $urandom_range(32'h7FFF_FFFF, 1);
        endcase
        r = make_req(FUNC_BITS, 6'($urandom_range(63)), bnd, random_seed());
        if (pick < 20)       r.func = FUNC_BITS;
        else if (pick < 42)  r.func = FUNC_BOUNDED;
        else if (pick < 56)  r.func = FUNC_LONG;
        else if (pick < 70)  r.func = FUNC_DOUBLE;
        else if (pick < 80)  r.func = FUNC_SET_SEED;
        else if (pick < 94)  r.func = FUNC_GET_SEED;
        else if (pick < 97)  r.func = FUNC_UNUSED_6;
        else                 r.func = FUNC_UNUSED_7;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        while (!calm && $urandom_range(99) < 36)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stop offering and hold until every owed result has come back.
    task automatic drain();
        req_valid <= 1'b0;
        // let the monitor note the last transfer before counting what is owed
        @(posedge clk);
        while (sb.owed() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [SEED_W-1:0] s);
        seed_we    <= 1'b1;
        seed_wdata <= s;
        @(posedge clk);
        seed_we    <= 1'b0;
        sb.load_seed(s);
    endtask

    task automatic run_phase(input logic [SEED_W-1:0] s, input int phase);
        write_seed(s);
        calm = (phase == 3);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (phase == 5 && i == 30) hold_now = 1'b1;
            send_request(random_request());
        end
        drain();
        calm = 1'b0;
    endtask

    task automatic run_directed();
        send_request(make_req(FUNC_BITS, 6'd0, 32'd5, '0));
        send_request(make_req(FUNC_BITS, 6'd1, 32'd5, '0));
        send_request(make_req(FUNC_BITS, 6'd31, 32'd5, '0));
        send_request(make_req(FUNC_BITS, 6'd32, 32'd5, '0));
        send_request(make_req(FUNC_BITS, 6'd33, 32'd5, '0));
        send_request(make_req(FUNC_BITS, 6'd63, 32'd5, '1));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'd0, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'hFFFF_FFFF, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'h8000_0000, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'd1, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'd2, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'h4000_0000, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'h7FFF_FFFF, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'd3, '0));
        send_request(make_req(FUNC_BOUNDED, 6'd0, 32'h4000_0001, '0));
        send_request(make_req(FUNC_LONG, 6'd0, 32'd0, '0));
        send_request(make_req(FUNC_DOUBLE, 6'd0, 32'd0, '0));
        send_request(make_req(FUNC_GET_SEED, 6'd0, 32'd0, '0));
        send_request(make_req(FUNC_SET_SEED, 6'd0, 32'd0, '0));
        send_request(make_req(FUNC_GET_SEED, 6'd0, 32'd0, '0));
        send_request(make_req(FUNC_BITS, 6'd32, 32'd0, '0));
        send_request(make_req(FUNC_SET_SEED, 6'd0, 32'd0, '1));
        send_request(make_req(FUNC_GET_SEED, 6'd0, 32'd0, '0));
        send_request(make_req(FUNC_UNUSED_6, 6'h3F, 32'hFFFF_FFFF, '1));
        send_request(make_req(FUNC_UNUSED_7, 6'h3F, 32'hFFFF_FFFF, '1));
        send_request(make_req(FUNC_GET_SEED, 6'd0, 32'd0, '0));
        drain();
    endtask

    initial
    begin
        sb       = new();
        calm     = 1'b0;
        hold_now = 1'b0;
        cycles   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed items run on the reset seed
        run_directed();
        run_phase('0, 0);
        run_phase('1, 1);
        for (int p = 2; p < 7; p++)
            run_phase({16'($urandom), $urandom}, p);
        if (sb.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hdl/lcg48_pkg.sv
hdl/lcg48_mul.sv
hdl/lcg48_rem.sv
hdl/lcg48_uniform_generator.sv
verif/lcg48_uniform_generator_tb.sv
